[hw/rtl/cmmc_pkg.sv]
package cmmc_pkg;

  localparam int unsigned CHAR_W            = 8;
  localparam int unsigned STACK_DEPTH_DFLT  = 256;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_MARKER     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SEPARATOR = 1'b1;

  localparam logic [CHAR_W-1:0] CENTER_MARKER_RST     = 8'd38;
  localparam logic [CHAR_W-1:0] SEGMENT_SEPARATOR_RST = 8'd35;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_cmd_t;

endpackage

[hw/rtl/cmmc_if.sv]
interface cmmc_in_if;
  logic                        valid;
  logic                        ready;
  logic [cmmc_pkg::CHAR_W-1:0] char_in;
  logic                        last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface cmmc_out_if;
  logic valid;
  logic ready;
  logic all_segments_match;
  logic stack_overflowed;

  modport source (output valid, output all_segments_match, output stack_overflowed,
                  input ready);
  modport sink   (input valid, input all_segments_match, input stack_overflowed,
                  output ready);
endinterface

[hw/rtl/cmmc_stack.sv]
module cmmc_stack #(
  parameter int unsigned STACK_DEPTH = cmmc_pkg::STACK_DEPTH_DFLT,
  localparam int unsigned IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmmc_pkg::stk_cmd_t          cmd_i,
  input  logic [cmmc_pkg::CHAR_W-1:0] wdata_i,
  output logic [cmmc_pkg::CHAR_W-1:0] top_o,
  output logic [CW-1:0]               count_o
);

  logic [cmmc_pkg::CHAR_W-1:0] mem [STACK_DEPTH];
  logic [CW-1:0]               count_q, count_d;
  logic [cmmc_pkg::CHAR_W-1:0] top_q, top_d;
  logic [cmmc_pkg::CHAR_W-1:0] rd_q;
  logic [CW-1:0]               raddr_full;
  logic [IW-1:0]               raddr;
  logic [IW-1:0]               waddr;

  // rd_q tracks the entry just below the top (count - 2)
  always_comb begin
    count_d = count_q;
    top_d   = top_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + CW'(1);
      top_d   = wdata_i;
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
      top_d   = rd_q;
    end
  end

  assign raddr_full = count_d - CW'(2);
  assign raddr      = raddr_full[IW-1:0];
  assign waddr      = count_q[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !cmd_i.clear) begin
      mem[waddr] <= wdata_i;
    end
    rd_q <= mem[raddr];
  end

  assign top_o   = top_q;
  assign count_o = count_q;

endmodule

[hw/rtl/center_marked_mirror_checker_top.sv]
// channel | dir | payload                                  | note
// in_i    | in  | char_in[7:0], last_char                  | one word per byte
// out_o   | out | all_segments_match, stack_overflowed     | one word per string
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i[7:0]   | 0 marker, 1 separator
//
// One byte per cycle while result words are taken; each byte is registered,
// then processed, and the result word shows up in the cycle after its last
// byte is processed. The stack is a single-port-write memory with a registered
// read of the entry below the top, so back-to-back pops do not stall.
// Reset clears all control state; stack contents are never cleared.
// in_i stalls only when a last byte is waiting and the result word is not taken.
module center_marked_mirror_checker_top #(
  parameter int unsigned STACK_DEPTH = cmmc_pkg::STACK_DEPTH_DFLT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  cmmc_in_if.sink                         in_i,
  cmmc_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [cmmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cmmc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [cmmc_pkg::CHAR_W-1:0] marker_q, sep_q;

  logic                        in_vld_q;
  logic [cmmc_pkg::CHAR_W-1:0] char_q;
  logic                        last_q;
  logic                        adv;

  logic past_q, past_d;
  logic segf_q, segf_d;
  logic strf_q, strf_d;
  logic ovf_q, ovf_d;

  logic out_vld_q;
  logic match_q, match_d;
  logic res_ovf_q, res_ovf_d;

  cmmc_pkg::stk_cmd_t          cmd;
  logic [cmmc_pkg::CHAR_W-1:0] top;
  logic [CW-1:0]               cnt;
  logic                        is_sep, is_mark, full, empty, mid_nz;
  logic                        seg_bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= cmmc_pkg::CENTER_MARKER_RST;
      sep_q    <= cmmc_pkg::SEGMENT_SEPARATOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmmc_pkg::CFG_CENTER_MARKER:     marker_q <= cfg_wdata_i;
        cmmc_pkg::CFG_SEGMENT_SEPARATOR: sep_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign adv        = in_vld_q && !(last_q && out_vld_q && !out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q <= in_i.char_in;
      last_q <= in_i.last_char;
    end
  end

  cmmc_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .wdata_i (char_q),
    .top_o   (top),
    .count_o (cnt)
  );

  assign is_sep  = (char_q == sep_q);
  assign is_mark = (char_q == marker_q);
  assign full    = (cnt == CW'(STACK_DEPTH));
  assign empty   = (cnt == '0);

  always_comb begin
    past_d    = past_q;
    segf_d    = segf_q;
    strf_d    = strf_q;
    ovf_d     = ovf_q;
    cmd       = '0;
    match_d   = match_q;
    res_ovf_d = res_ovf_q;
    mid_nz    = 1'b0;
    seg_bad   = 1'b0;
    if (adv) begin
      if (is_sep) begin
        strf_d    = strf_q | segf_q | !past_q | !empty;
        past_d    = 1'b0;
        segf_d    = 1'b0;
        cmd.clear = 1'b1;
      end else if (!segf_q) begin
        if (!past_q) begin
          if (is_mark) begin
            past_d = 1'b1;
          end else if (full) begin
            ovf_d  = 1'b1;
            segf_d = 1'b1;
          end else begin
            cmd.push = 1'b1;
          end
        end else if (empty || (top != char_q)) begin
          segf_d = 1'b1;
        end else begin
          cmd.pop = 1'b1;
        end
      end
      if (last_q) begin
        if (cmd.clear) begin
          mid_nz = 1'b0;
        end else if (cmd.push) begin
          mid_nz = 1'b1;
        end else if (cmd.pop) begin
          mid_nz = (cnt != CW'(1));
        end else begin
          mid_nz = !empty;
        end
        seg_bad   = segf_d | !past_d | mid_nz;
        match_d   = !(strf_d | seg_bad);
        res_ovf_d = ovf_d;
        past_d    = 1'b0;
        segf_d    = 1'b0;
        strf_d    = 1'b0;
        ovf_d     = 1'b0;
        cmd.clear = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      past_q    <= 1'b0;
      segf_q    <= 1'b0;
      strf_q    <= 1'b0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      past_q <= past_d;
      segf_q <= segf_d;
      strf_q <= strf_d;
      ovf_q  <= ovf_d;
      if (adv && last_q) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    match_q   <= match_d;
    res_ovf_q <= res_ovf_d;
  end

  assign out_o.valid              = out_vld_q;
  assign out_o.all_segments_match = match_q;
  assign out_o.stack_overflowed   = res_ovf_q;

endmodule

[hw/rtl/cmmc_checker.sv]
module cmmc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_match_i,
  input logic out_ovf_i
);

  // result word holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // a fresh result follows its last byte through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2))
    else $error("result word without a last byte");

  // input only backs up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  // overflow always fails the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ovf_i |-> !out_match_i)
    else $error("overflow reported with a passing string");

endmodule

bind center_marked_mirror_checker_top cmmc_checker u_cmmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_char),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_match_i (out_o.all_segments_match),
  .out_ovf_i   (out_o.stack_overflowed)
);
